@@ src/c_token_lexer_core_defines.svh @@
// ----------------------------------------------------------------------------
// c_token_lexer_core_defines
// assertion macros of the lexer, used by the output stage ctl_back
// ----------------------------------------------------------------------------
`ifndef C_TOKEN_LEXER_CORE_DEFINES_SVH
`define C_TOKEN_LEXER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define CTL_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CTL_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CTL_ASSERT(name, clk, rst, prop, msg)
`define CTL_ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

@@ src/ctl_pkg.sv @@
// ----------------------------------------------------------------------------
// ctl_pkg
// types, token codes and helper functions of the token lexer
// ----------------------------------------------------------------------------
package ctl_pkg;

   localparam int OFFSET_BITS_DEF = 20;
   localparam int ROW_BITS_DEF    = 16;
   localparam int COL_BITS        = 16;
   localparam int Q_DEPTH         = 4;
   localparam int Q_PTR_BITS      = 2;
   localparam int Q_CNT_BITS      = 3;

   localparam logic [5:0] TK_LPAREN  = 6'd0;
   localparam logic [5:0] TK_RPAREN  = 6'd1;
   localparam logic [5:0] TK_LBRACK  = 6'd2;
   localparam logic [5:0] TK_RBRACK  = 6'd3;
   localparam logic [5:0] TK_LBRACE  = 6'd4;
   localparam logic [5:0] TK_RBRACE  = 6'd5;
   localparam logic [5:0] TK_COMMA   = 6'd6;
   localparam logic [5:0] TK_DOT     = 6'd7;
   localparam logic [5:0] TK_VARARG  = 6'd8;
   localparam logic [5:0] TK_MINUS   = 6'd9;
   localparam logic [5:0] TK_PLUS    = 6'd10;
   localparam logic [5:0] TK_SEMI    = 6'd11;
   localparam logic [5:0] TK_STAR    = 6'd12;
   localparam logic [5:0] TK_SLASH   = 6'd13;
   localparam logic [5:0] TK_PERCENT = 6'd15;
   localparam logic [5:0] TK_BANG    = 6'd16;
   localparam logic [5:0] TK_ASSIGN  = 6'd18;
   localparam logic [5:0] TK_LT      = 6'd20;
   localparam logic [5:0] TK_GT      = 6'd22;
   localparam logic [5:0] TK_AMP     = 6'd24;
   localparam logic [5:0] TK_PIPE    = 6'd26;
   localparam logic [5:0] TK_INT     = 6'd28;
   localparam logic [5:0] TK_FLOAT   = 6'd29;
   localparam logic [5:0] TK_STRING  = 6'd30;
   localparam logic [5:0] TK_CHAR    = 6'd31;
   localparam logic [5:0] TK_IDENT   = 6'd32;
   localparam logic [5:0] TK_RETURN  = 6'd33;
   localparam logic [5:0] TK_IF      = 6'd34;
   localparam logic [5:0] TK_ELSE    = 6'd35;
   localparam logic [5:0] TK_FOR     = 6'd36;
   localparam logic [5:0] TK_WHILE   = 6'd37;
   localparam logic [5:0] TK_STRUCT  = 6'd38;
   localparam logic [5:0] TK_TYPEDEF = 6'd39;
   localparam logic [5:0] TK_EOF     = 6'd40;
   // kind returned for a dropped name
   localparam logic [5:0] TK_DROP    = 6'd0;

   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_CHAR  = 2'd1;
   localparam logic [1:0] ERR_UNTERM = 2'd2;
   localparam logic [1:0] ERR_OVFL  = 2'd3;

   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_CR  = 8'h0D;

   localparam logic [31:0] INT_LIMIT = 32'h8000_0000;

   typedef enum logic [3:0] {
      M_IDLE, M_OP2, M_DOT1, M_DOT2, M_STR, M_CHR1, M_CHR2,
      M_NUM, M_NUMDOT, M_FRAC, M_NAME
   } mode_type;

   typedef struct packed {
      logic [5:0]  kind;
      logic [15:0] row;
      logic [15:0] column;
      logic [19:0] start;
      logic [19:0] length;
      logic [30:0] value;
      logic [1:0]  err;
   } result_type;

   typedef struct packed {
      logic [1:0]            cnt;
      result_type [2:0]      res;
   } bundle_type;

   typedef struct packed {
      logic       valid;
      bundle_type data;
   } q_port_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   function automatic logic [5:0] single_kind(input logic [7:0] c);
      case (c)
         "/":     return TK_SLASH;
         "!":     return TK_BANG;
         "=":     return TK_ASSIGN;
         "<":     return TK_LT;
         ">":     return TK_GT;
         "&":     return TK_AMP;
         default: return TK_PIPE;
      endcase
   endfunction

   function automatic logic [7:0] second_char(input logic [7:0] c);
      case (c)
         "/":     return "/";
         "&":     return "&";
         "|":     return "|";
         default: return "=";
      endcase
   endfunction

   // window holds the name little-endian, first char in the low byte
   function automatic logic [5:0] kw_lookup(input logic [63:0] win, input logic [3:0] len);
      logic [5:0] kind;
      kind = TK_IDENT;
      if (len == 4'd6 && win == {16'h0, "nruter"})  kind = TK_RETURN;
      if (len == 4'd2 && win == {48'h0, "fi"})      kind = TK_IF;
      if (len == 4'd4 && win == {32'h0, "esle"})    kind = TK_ELSE;
      if (len == 4'd3 && win == {40'h0, "rof"})     kind = TK_FOR;
      if (len == 4'd5 && win == {24'h0, "elihw"})   kind = TK_WHILE;
      if (len == 4'd6 && win == {16'h0, "tcurts"})  kind = TK_STRUCT;
      if (len == 4'd7 && win == {8'h0, "fedepyt"})  kind = TK_TYPEDEF;
      if (len == 4'd5 && win == {24'h0, "tsnoc"})   kind = TK_DROP;
      return kind;
   endfunction

endpackage

@@ src/ctl_if.sv @@
// ----------------------------------------------------------------------------
// ctl_if
// request and response channel interfaces of the token lexer
// ----------------------------------------------------------------------------
interface ctl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;
   modport source (output valid, text_byte, end_of_text, input ready);
   modport sink (input valid, text_byte, end_of_text, output ready);
endinterface

interface ctl_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  token_kind;
   logic [15:0] token_row;
   logic [15:0] token_column;
   logic [19:0] span_start;
   logic [19:0] span_length;
   logic [30:0] literal_value;
   logic [1:0]  error_code;
   logic        last_result;
   modport source (output valid, token_kind, token_row, token_column, span_start,
                   span_length, literal_value, error_code, last_result, input ready);
   modport sink (input valid, token_kind, token_row, token_column, span_start,
                 span_length, literal_value, error_code, last_result, output ready);
endinterface

@@ src/c_token_lexer_core.sv @@
// ----------------------------------------------------------------------------
// c_token_lexer_core
// streaming lexer for a small C-like language, one source byte per beat
// ----------------------------------------------------------------------------
// The scanner takes one byte every cycle while its four-entry bundle queue has
// room, and turns it into zero to three results in that same cycle. The output
// stage sends one result per cycle while the receiver is ready; with one result
// or fewer per byte and a ready receiver the block runs at one byte per clock. A
// result passes through the bundle queue and the output register before it
// appears. After an error or end of text the block drops every byte until reset.
module c_token_lexer_core
   import ctl_pkg::*;
#(
   parameter int OFFSET_BITS = OFFSET_BITS_DEF,
   parameter int ROW_BITS    = ROW_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   ctl_req_if.sink   req_if,
   ctl_rsp_if.source rsp_if,
   input  logic      csr_write_en,
   input  logic      csr_write_data
);

   logic       q_full, push, pop, take;
   bundle_type push_data;
   q_port_type head;

   assign req_if.ready = !q_full;
   assign take         = req_if.valid && !q_full;

   ctl_front #(
      .OFFSET_BITS (OFFSET_BITS),
      .ROW_BITS    (ROW_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .take           (take),
      .text_byte      (req_if.text_byte),
      .end_of_text    (req_if.end_of_text),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .push           (push),
      .push_data      (push_data)
   );

   ctl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .full      (q_full),
      .head      (head)
   );

   ctl_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp_if)
   );

endmodule

@@ src/ctl_front.sv @@
// ----------------------------------------------------------------------------
// ctl_front
// scanner: takes one byte per beat, tracks lexer state, builds result bundles
// ----------------------------------------------------------------------------
module ctl_front
   import ctl_pkg::*;
#(
   parameter int OFFSET_BITS = OFFSET_BITS_DEF,
   parameter int ROW_BITS    = ROW_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       take,
   input  logic [7:0] text_byte,
   input  logic       end_of_text,
   input  logic       csr_write_en,
   input  logic       csr_write_data,
   output logic       push,
   output bundle_type push_data
);

   mode_type               mode_ff, mode_in;
   logic [ROW_BITS-1:0]    row_ff, row_in;
   logic [COL_BITS-1:0]    col_ff, col_in;
   logic [OFFSET_BITS-1:0] off_ff, off_in;
   logic [OFFSET_BITS-1:0] tso_ff, tso_in;
   logic [COL_BITS-1:0]    tsc_ff, tsc_in;
   logic [31:0]            acc_ff, acc_in;
   logic [63:0]            win_ff, win_in;
   logic [3:0]             nlen_ff, nlen_in;
   logic                   stop_ff, stop_in;

   logic [1:0]             n;
   result_type [2:0]       res;
   logic                   again, nl_idle, nl_str;
   logic [7:0]             c;
   logic [OFFSET_BITS-1:0] pos, endp;
   logic [34:0]            prod;
   logic [5:0]             kw;
   logic [5:0]             pk;

   function automatic result_type mk(input logic [5:0] kind, input logic [ROW_BITS-1:0] row,
                                     input logic [COL_BITS-1:0] column,
                                     input logic [OFFSET_BITS-1:0] start,
                                     input logic [OFFSET_BITS-1:0] length,
                                     input logic [30:0] value, input logic [1:0] err);
      result_type r;
      r.kind   = kind;
      r.row    = 16'(row);
      r.column = column;
      r.start  = 20'(start);
      r.length = 20'(length);
      r.value  = value;
      r.err    = err;
      return r;
   endfunction

   always_comb begin
      mode_in = mode_ff;
      row_in  = row_ff;
      col_in  = col_ff;
      off_in  = off_ff;
      tso_in  = tso_ff;
      tsc_in  = tsc_ff;
      acc_in  = acc_ff;
      win_in  = win_ff;
      nlen_in = nlen_ff;
      stop_in = stop_ff;
      n       = 2'd0;
      res     = '0;
      again   = 1'b0;
      nl_idle = 1'b0;
      nl_str  = 1'b0;
      pk      = TK_PERCENT;
      c       = text_byte;
      pos     = off_ff;
      endp    = off_ff;
      prod    = ({3'b0, acc_ff} << 3) + ({3'b0, acc_ff} << 1) + 35'(c - "0");
      kw      = kw_lookup(win_ff, nlen_ff);

      if (stop_ff) begin
         // stopped: beats are taken and dropped
      end else if (end_of_text) begin
         unique case (mode_ff)
            M_OP2: begin
               res[n] = mk(single_kind(win_ff[7:0]), row_in, tsc_in, tso_in,
                           OFFSET_BITS'(1), '0, ERR_NONE);
               n = n + 2'd1;
            end
            M_DOT2: begin
               res[n] = mk(TK_DOT, row_in, tsc_in, tso_in, OFFSET_BITS'(1), '0, ERR_NONE);
               n = n + 2'd1;
               tso_in = tso_in + OFFSET_BITS'(1);
               tsc_in = tsc_in + COL_BITS'(1);
               res[n] = mk(TK_DOT, row_in, tsc_in, tso_in, OFFSET_BITS'(1), '0, ERR_NONE);
               n = n + 2'd1;
            end
            M_DOT1: begin
               res[n] = mk(TK_DOT, row_in, tsc_in, tso_in, OFFSET_BITS'(1), '0, ERR_NONE);
               n = n + 2'd1;
            end
            M_STR, M_CHR1, M_CHR2: begin
               res[n] = mk(TK_EOF, row_in, tsc_in, tso_in, pos - tso_in, '0, ERR_UNTERM);
               n = n + 2'd1;
               stop_in = 1'b1;
            end
            M_NUM, M_NUMDOT: begin
               endp = (mode_ff == M_NUMDOT) ? pos - OFFSET_BITS'(1) : pos;
               if (acc_ff >= INT_LIMIT) begin
                  res[n] = mk(TK_EOF, row_in, tsc_in, tso_in, endp - tso_in, '0, ERR_OVFL);
                  stop_in = 1'b1;
               end else begin
                  res[n] = mk(TK_INT, row_in, tsc_in, tso_in, endp - tso_in, acc_ff[30:0],
                              ERR_NONE);
               end
               n = n + 2'd1;
               if (!stop_in && mode_ff == M_NUMDOT) begin
                  tso_in = pos - OFFSET_BITS'(1);
                  tsc_in = col_ff - COL_BITS'(1);
                  res[n] = mk(TK_DOT, row_in, tsc_in, tso_in, OFFSET_BITS'(1), '0, ERR_NONE);
                  n = n + 2'd1;
               end
            end
            M_FRAC: begin
               res[n] = mk(TK_FLOAT, row_in, tsc_in, tso_in, pos - tso_in, '0, ERR_NONE);
               n = n + 2'd1;
            end
            M_NAME: begin
               if (kw != TK_DROP) begin
                  res[n] = mk(kw, row_in, tsc_in, tso_in, pos - tso_in, '0, ERR_NONE);
                  n = n + 2'd1;
               end
            end
            default: begin
            end
         endcase
         if (!stop_in) begin
            res[n] = mk(TK_EOF, row_in, tsc_in, pos, '0, '0, ERR_NONE);
            n = n + 2'd1;
         end
         mode_in = M_IDLE;
         stop_in = 1'b1;
      end else begin
         mode_in = M_IDLE;
         unique case (mode_ff)
            M_OP2: begin
               if (c == second_char(win_ff[7:0])) begin
                  res[n] = mk(single_kind(win_ff[7:0]) + 6'd1, row_in, tsc_in, tso_in,
                              OFFSET_BITS'(2), '0, ERR_NONE);
               end else begin
                  res[n] = mk(single_kind(win_ff[7:0]), row_in, tsc_in, tso_in,
                              OFFSET_BITS'(1), '0, ERR_NONE);
                  again = 1'b1;
               end
               n = n + 2'd1;
            end
            M_DOT1: begin
               if (c == ".") begin
                  mode_in = M_DOT2;
               end else begin
                  res[n] = mk(TK_DOT, row_in, tsc_in, tso_in, OFFSET_BITS'(1), '0, ERR_NONE);
                  n = n + 2'd1;
                  again = 1'b1;
               end
            end
            M_DOT2: begin
               if (c == ".") begin
                  res[n] = mk(TK_VARARG, row_in, tsc_in, tso_in, OFFSET_BITS'(3), '0,
                              ERR_NONE);
                  n = n + 2'd1;
               end else begin
                  res[n] = mk(TK_DOT, row_in, tsc_in, tso_in, OFFSET_BITS'(1), '0, ERR_NONE);
                  n = n + 2'd1;
                  res[n] = mk(TK_DOT, row_in, tsc_in + COL_BITS'(1), tso_in + OFFSET_BITS'(1),
                              OFFSET_BITS'(1), '0, ERR_NONE);
                  n = n + 2'd1;
                  again = 1'b1;
               end
            end
            M_STR: begin
               mode_in = M_STR;
               if (c == "\"") begin
                  mode_in = M_IDLE;
                  res[n] = mk(TK_STRING, row_in, tsc_in, tso_in + OFFSET_BITS'(1),
                              pos - tso_in - OFFSET_BITS'(1), '0, ERR_NONE);
                  n = n + 2'd1;
               end else if (c == CH_LF) begin
                  row_in = row_in + ROW_BITS'(1);
                  nl_str = 1'b1;
               end
            end
            M_CHR1: begin
               win_in  = {56'h0, c};
               mode_in = M_CHR2;
            end
            M_CHR2: begin
               res[n] = mk(TK_CHAR, row_in, tsc_in, tso_in, OFFSET_BITS'(3),
                           {23'h0, win_ff[7:0]}, ERR_NONE);
               n = n + 2'd1;
            end
            M_NUM: begin
               mode_in = M_NUM;
               if (is_digit(c)) begin
                  if (nlen_ff == 4'd0) begin
                     // saturate so overflow stays visible
                     acc_in = (prod > 35'(INT_LIMIT)) ? INT_LIMIT : prod[31:0];
                  end
               end else if (is_alpha(c)) begin
                  nlen_in = 4'd1;
               end else if (c == ".") begin
                  mode_in = M_NUMDOT;
               end else begin
                  mode_in = M_IDLE;
                  if (acc_ff >= INT_LIMIT) begin
                     res[n] = mk(TK_EOF, row_in, tsc_in, tso_in, pos - tso_in, '0, ERR_OVFL);
                     stop_in = 1'b1;
                  end else begin
                     res[n] = mk(TK_INT, row_in, tsc_in, tso_in, pos - tso_in, acc_ff[30:0],
                                 ERR_NONE);
                  end
                  n = n + 2'd1;
                  again = 1'b1;
               end
            end
            M_NUMDOT: begin
               if (is_digit(c)) begin
                  mode_in = M_FRAC;
               end else begin
                  endp = pos - OFFSET_BITS'(1);
                  if (acc_ff >= INT_LIMIT) begin
                     res[n] = mk(TK_EOF, row_in, tsc_in, tso_in, endp - tso_in, '0, ERR_OVFL);
                     stop_in = 1'b1;
                  end else begin
                     res[n] = mk(TK_INT, row_in, tsc_in, tso_in, endp - tso_in, acc_ff[30:0],
                                 ERR_NONE);
                  end
                  n = n + 2'd1;
                  if (!stop_in) begin
                     tso_in = endp;
                     tsc_in = col_ff - COL_BITS'(1);
                     if (c == ".") begin
                        mode_in = M_DOT2;
                     end else begin
                        res[n] = mk(TK_DOT, row_in, tsc_in, tso_in, OFFSET_BITS'(1), '0,
                                    ERR_NONE);
                        n = n + 2'd1;
                        again = 1'b1;
                     end
                  end
               end
            end
            M_FRAC: begin
               mode_in = M_FRAC;
               if (!is_digit(c)) begin
                  mode_in = M_IDLE;
                  res[n] = mk(TK_FLOAT, row_in, tsc_in, tso_in, pos - tso_in, '0, ERR_NONE);
                  n = n + 2'd1;
                  again = 1'b1;
               end
            end
            M_NAME: begin
               mode_in = M_NAME;
               if (is_alpha(c) || is_digit(c) || c == "_") begin
                  if (nlen_ff < 4'd8) begin
                     win_in = win_ff | ({56'h0, c} << {nlen_ff[2:0], 3'b000});
                  end
                  if (nlen_ff < 4'd9) begin
                     nlen_in = nlen_ff + 4'd1;
                  end
               end else begin
                  mode_in = M_IDLE;
                  if (kw != TK_DROP) begin
                     res[n] = mk(kw, row_in, tsc_in, tso_in, pos - tso_in, '0, ERR_NONE);
                     n = n + 2'd1;
                  end
                  again = 1'b1;
               end
            end
            default: begin
               again = 1'b1;
            end
         endcase

         if (again && !stop_in) begin
            tso_in = pos;
            tsc_in = col_ff;
            case (c) inside
               "(", ")", "[", "]", "{", "}", ",", "-", "+", ";", "*", "%": begin
                  case (c)
                     "(":     pk = TK_LPAREN;
                     ")":     pk = TK_RPAREN;
                     "[":     pk = TK_LBRACK;
                     "]":     pk = TK_RBRACK;
                     "{":     pk = TK_LBRACE;
                     "}":     pk = TK_RBRACE;
                     ",":     pk = TK_COMMA;
                     "-":     pk = TK_MINUS;
                     "+":     pk = TK_PLUS;
                     ";":     pk = TK_SEMI;
                     "*":     pk = TK_STAR;
                     default: pk = TK_PERCENT;
                  endcase
                  res[n] = mk(pk, row_in, col_ff, pos, OFFSET_BITS'(1), '0, ERR_NONE);
                  n = n + 2'd1;
               end
               ".": mode_in = M_DOT1;
               "/", "!", "=", "<", ">", "&", "|": begin
                  mode_in = M_OP2;
                  win_in  = {56'h0, c};
               end
               " ", CH_CR, CH_TAB: begin
               end
               CH_LF: begin
                  row_in  = row_in + ROW_BITS'(1);
                  nl_idle = 1'b1;
               end
               "\"": mode_in = M_STR;
               "'":  mode_in = M_CHR1;
               default: begin
                  if (is_digit(c)) begin
                     mode_in = M_NUM;
                     acc_in  = {24'h0, c - "0"};
                     nlen_in = 4'd0;
                  end else if (is_alpha(c) || c == "_") begin
                     mode_in = M_NAME;
                     win_in  = {56'h0, c};
                     nlen_in = 4'd1;
                  end else begin
                     res[n] = mk(TK_EOF, row_in, col_ff, pos, OFFSET_BITS'(1), '0, ERR_CHAR);
                     n = n + 2'd1;
                     stop_in = 1'b1;
                     mode_in = M_IDLE;
                  end
               end
            endcase
         end

         off_in = pos + OFFSET_BITS'(1);
         col_in = nl_idle ? '0 : (nl_str ? COL_BITS'(1) : col_ff + COL_BITS'(1));
      end
   end

   assign push          = take && (n != 2'd0);
   assign push_data.cnt = n;
   assign push_data.res = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         row_ff  <= ROW_BITS'(1);
         col_ff  <= '0;
         off_ff  <= '0;
         tso_ff  <= '0;
         tsc_ff  <= '0;
         acc_ff  <= '0;
         win_ff  <= '0;
         nlen_ff <= '0;
         stop_ff <= 1'b0;
      end else if (take) begin
         mode_ff <= mode_in;
         row_ff  <= row_in;
         col_ff  <= col_in;
         off_ff  <= off_in;
         tso_ff  <= tso_in;
         tsc_ff  <= tsc_in;
         acc_ff  <= acc_in;
         win_ff  <= win_in;
         nlen_ff <= nlen_in;
         stop_ff <= stop_in;
      end else if (csr_write_en) begin
         // the row start only follows while nothing has been scanned
         if (off_ff == '0 && mode_ff == M_IDLE && !stop_ff) begin
            row_ff <= ROW_BITS'(csr_write_data);
         end
      end
   end

endmodule

@@ src/ctl_queue.sv @@
// ----------------------------------------------------------------------------
// ctl_queue
// short bundle queue between scanner and output stage
// ----------------------------------------------------------------------------
module ctl_queue
   import ctl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  bundle_type push_data,
   input  logic       pop,
   output logic       full,
   output q_port_type head
);

   bundle_type             mem_ff [Q_DEPTH];
   logic [Q_PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                   do_pop;

   always_comb begin
      do_pop    = pop && (cnt_ff != '0);
      wr_ptr_in = push ? wr_ptr_ff + Q_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + Q_PTR_BITS'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + Q_CNT_BITS'(push) - Q_CNT_BITS'(do_pop);
   end

   assign full       = (cnt_ff == Q_CNT_BITS'(Q_DEPTH));
   assign head.valid = (cnt_ff != '0);
   assign head.data  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

@@ src/ctl_back.sv @@
// ----------------------------------------------------------------------------
// ctl_back
// output stage: while the receiver is ready, unpacks each bundle into one result beat per cycle
// ----------------------------------------------------------------------------
`include "c_token_lexer_core_defines.svh"
module ctl_back
   import ctl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  q_port_type head,
   output logic       pop,
   ctl_rsp_if.source  rsp
);

   bundle_type bnd_ff;
   logic [1:0] idx_ff;
   logic       busy_ff;
   logic       fire, at_last;
   result_type cur;

   always_comb begin
      fire    = busy_ff && rsp.ready;
      at_last = (idx_ff == bnd_ff.cnt - 2'd1);
      pop     = head.valid && (!busy_ff || (fire && at_last));
      cur     = bnd_ff.res[idx_ff];
   end

   assign rsp.valid         = busy_ff;
   assign rsp.token_kind    = cur.kind;
   assign rsp.token_row     = cur.row;
   assign rsp.token_column  = cur.column;
   assign rsp.span_start    = cur.start;
   assign rsp.span_length   = cur.length;
   assign rsp.literal_value = cur.value;
   assign rsp.error_code    = cur.err;
   assign rsp.last_result   = at_last;

   always_ff @(posedge clock) begin
      if (pop) begin
         bnd_ff <= head.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (pop) begin
         busy_ff <= 1'b1;
         idx_ff  <= '0;
      end else if (fire) begin
         if (at_last) begin
            busy_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + 2'd1;
         end
      end
   end

   `CTL_ASSERT(a_busy_nonempty, clock, reset, busy_ff |-> bnd_ff.cnt != 2'd0, "empty bundle shown")
   `CTL_ASSERT(a_idx_range, clock, reset, busy_ff |-> idx_ff < bnd_ff.cnt, "beat index past bundle")
   `CTL_ASSERT(a_stall_hold, clock, reset, (busy_ff && !rsp.ready) |=> (busy_ff && $stable(idx_ff)), "stalled beat moved")
   `CTL_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) |-> !busy_ff, "output busy after reset")

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the token lexer: a byte stream of well-formed C-like
// text with random content runs through four idling phases, each byte is
// predicted in the scoreboard and every token beat is checked field by field;
// the stream ends with one stopping condition and ignored trailing bytes
// ----------------------------------------------------------------------------
module tb_top;
   import ctl_pkg::*;

   typedef struct {
      result_type tok;
      logic       last;
   } token_beat_t;

   class token_scoreboard;
      mode_type    mode;
      logic        first_row;
      logic [15:0] row;
      logic [15:0] col;
      logic [19:0] offset;
      logic [19:0] tok_off;
      logic [15:0] tok_col;
      logic [31:0] acc;
      logic        num_tail;
      logic [7:0]  op_first;
      logic [7:0]  chr_val;
      string       name_str;
      int          name_len;
      logic        stopped;
      logic        nl_idle;
      logic        nl_str;
      int          beats_now;
      int          fails;
      token_beat_t expected_q[$];

      function new();
         first_row = 1'b1;
         mode      = M_IDLE;
         row       = 16'd1;
         col       = '0;
         offset    = '0;
         tok_off   = '0;
         tok_col   = '0;
         acc       = '0;
         num_tail  = 1'b0;
         name_str  = "";
         name_len  = 0;
         stopped   = 1'b0;
         fails     = 0;
      endfunction

      function void write_first_row(logic v);
         first_row = v;
         if (offset == 0 && mode == M_IDLE && !stopped) row = {15'd0, v};
      endfunction

      function void add_tok(logic [5:0] k, logic [15:0] c, logic [19:0] s,
                            logic [19:0] l, logic [30:0] v, logic [1:0] e);
         token_beat_t b;
         b.tok.kind   = k;
         b.tok.row    = row;
         b.tok.column = c;
         b.tok.start  = s;
         b.tok.length = l;
         b.tok.value  = v;
         b.tok.err    = e;
         b.last       = 1'b0;
         expected_q.push_back(b);
         beats_now++;
      endfunction

      function void halt_with(logic [1:0] e, logic [19:0] l);
         stopped = 1'b1;
         mode    = M_IDLE;
         add_tok(TK_EOF, tok_col, tok_off, l, '0, e);
      endfunction

      function logic is_dig(logic [7:0] c);
         return c inside {["0":"9"]};
      endfunction

      function logic is_let(logic [7:0] c);
         return c inside {["a":"z"], ["A":"Z"]};
      endfunction

      function logic [5:0] op_kind(logic [7:0] c);
         case (c)
            "/": return TK_SLASH;
            "!": return TK_BANG;
            "=": return TK_ASSIGN;
            "<": return TK_LT;
            ">": return TK_GT;
            "&": return TK_AMP;
            default: return TK_PIPE;
         endcase
      endfunction

      function logic [7:0] op_pair(logic [7:0] c);
         if (c == "/" || c == "&" || c == "|") return c;
         return "=";
      endfunction

      function void close_number(logic [19:0] endpos);
         mode = M_IDLE;
         if (acc >= INT_LIMIT) halt_with(ERR_OVFL, endpos - tok_off);
         else add_tok(TK_INT, tok_col, tok_off, endpos - tok_off, acc[30:0], ERR_NONE);
      endfunction

      function void close_name(logic [19:0] endpos);
         logic [5:0] k;
         mode = M_IDLE;
         k = TK_IDENT;
         if (name_len <= 7) begin
            case (name_str)
               "return":  k = TK_RETURN;
               "if":      k = TK_IF;
               "else":    k = TK_ELSE;
               "for":     k = TK_FOR;
               "while":   k = TK_WHILE;
               "struct":  k = TK_STRUCT;
               "typedef": k = TK_TYPEDEF;
               "const":   return;
               default:   k = TK_IDENT;
            endcase
         end
         add_tok(k, tok_col, tok_off, endpos - tok_off, '0, ERR_NONE);
      endfunction

      function void open_token(logic [7:0] c, logic [19:0] pos, logic [15:0] cl);
         tok_off = pos;
         tok_col = cl;
         case (c)
            "(": add_tok(TK_LPAREN, cl, pos, 1, '0, ERR_NONE);
            ")": add_tok(TK_RPAREN, cl, pos, 1, '0, ERR_NONE);
            "[": add_tok(TK_LBRACK, cl, pos, 1, '0, ERR_NONE);
            "]": add_tok(TK_RBRACK, cl, pos, 1, '0, ERR_NONE);
            "{": add_tok(TK_LBRACE, cl, pos, 1, '0, ERR_NONE);
            "}": add_tok(TK_RBRACE, cl, pos, 1, '0, ERR_NONE);
            ",": add_tok(TK_COMMA, cl, pos, 1, '0, ERR_NONE);
            "-": add_tok(TK_MINUS, cl, pos, 1, '0, ERR_NONE);
            "+": add_tok(TK_PLUS, cl, pos, 1, '0, ERR_NONE);
            ";": add_tok(TK_SEMI, cl, pos, 1, '0, ERR_NONE);
            "*": add_tok(TK_STAR, cl, pos, 1, '0, ERR_NONE);
            "%": add_tok(TK_PERCENT, cl, pos, 1, '0, ERR_NONE);
            ".": mode = M_DOT1;
            "/", "!", "=", "<", ">", "&", "|": begin
               mode     = M_OP2;
               op_first = c;
            end
            " ", CH_CR, CH_TAB: ;
            CH_LF: begin
               row     = row + 16'd1;
               nl_idle = 1'b1;
            end
            "\"": mode = M_STR;
            "'": mode = M_CHR1;
            default: begin
               if (is_dig(c)) begin
                  mode     = M_NUM;
                  acc      = {24'd0, c - 8'd48};
                  num_tail = 1'b0;
               end else if (is_let(c) || c == "_") begin
                  mode     = M_NAME;
                  name_str = $sformatf("%c", c);
                  name_len = 1;
               end else begin
                  halt_with(ERR_CHAR, 20'd1);
               end
            end
         endcase
      endfunction

      function void flush_text();
         logic [19:0] pos;
         pos = offset;
         case (mode)
            M_OP2: add_tok(op_kind(op_first), tok_col, tok_off, 1, '0, ERR_NONE);
            M_DOT1: add_tok(TK_DOT, tok_col, tok_off, 1, '0, ERR_NONE);
            M_DOT2: begin
               add_tok(TK_DOT, tok_col, tok_off, 1, '0, ERR_NONE);
               tok_off = tok_off + 20'd1;
               tok_col = tok_col + 16'd1;
               add_tok(TK_DOT, tok_col, tok_off, 1, '0, ERR_NONE);
            end
            M_STR, M_CHR1, M_CHR2: halt_with(ERR_UNTERM, pos - tok_off);
            M_NUM: close_number(pos);
            M_NUMDOT: begin
               close_number(pos - 20'd1);
               if (!stopped) begin
                  tok_off = pos - 20'd1;
                  tok_col = col - 16'd1;
                  add_tok(TK_DOT, tok_col, tok_off, 1, '0, ERR_NONE);
               end
            end
            M_FRAC: add_tok(TK_FLOAT, tok_col, tok_off, pos - tok_off, '0, ERR_NONE);
            M_NAME: close_name(pos);
            default: ;
         endcase
         if (!stopped) begin
            add_tok(TK_EOF, tok_col, pos, 0, '0, ERR_NONE);
            mode    = M_IDLE;
            stopped = 1'b1;
         end
      endfunction

      // one accepted input beat
      function void note_byte(logic [7:0] c, logic eot);
         logic [19:0] pos;
         logic [15:0] cl;
         logic        again;
         logic [63:0] t;
         beats_now = 0;
         if (stopped) return;
         if (eot) begin
            flush_text();
         end else begin
            pos     = offset;
            cl      = col;
            again   = 1'b0;
            nl_idle = 1'b0;
            nl_str  = 1'b0;
            case (mode)
               M_OP2: begin
                  mode = M_IDLE;
                  if (c == op_pair(op_first)) begin
                     add_tok(op_kind(op_first) + 6'd1, tok_col, tok_off, 2, '0, ERR_NONE);
                  end else begin
                     add_tok(op_kind(op_first), tok_col, tok_off, 1, '0, ERR_NONE);
                     again = 1'b1;
                  end
               end
               M_DOT1: begin
                  if (c == ".") mode = M_DOT2;
                  else begin
                     add_tok(TK_DOT, tok_col, tok_off, 1, '0, ERR_NONE);
                     mode  = M_IDLE;
                     again = 1'b1;
                  end
               end
               M_DOT2: begin
                  mode = M_IDLE;
                  if (c == ".") add_tok(TK_VARARG, tok_col, tok_off, 3, '0, ERR_NONE);
                  else begin
                     add_tok(TK_DOT, tok_col, tok_off, 1, '0, ERR_NONE);
                     add_tok(TK_DOT, tok_col + 16'd1, tok_off + 20'd1, 1, '0, ERR_NONE);
                     again = 1'b1;
                  end
               end
               M_STR: begin
                  if (c == "\"") begin
                     mode = M_IDLE;
                     add_tok(TK_STRING, tok_col, tok_off + 20'd1, pos - tok_off - 20'd1,
                             '0, ERR_NONE);
                  end else if (c == CH_LF) begin
                     row    = row + 16'd1;
                     nl_str = 1'b1;
                  end
               end
               M_CHR1: begin
                  chr_val = c;
                  mode    = M_CHR2;
               end
               M_CHR2: begin
                  mode = M_IDLE;
                  add_tok(TK_CHAR, tok_col, tok_off, 3, {23'd0, chr_val}, ERR_NONE);
               end
               M_NUM: begin
                  if (is_dig(c)) begin
                     if (!num_tail) begin
                        t   = {32'd0, acc} * 64'd10 + {56'd0, c - 8'd48};
                        acc = (t > {32'd0, INT_LIMIT}) ? INT_LIMIT : t[31:0];
                     end
                  end else if (is_let(c)) begin
                     num_tail = 1'b1;
                  end else if (c == ".") begin
                     mode = M_NUMDOT;
                  end else begin
                     close_number(pos);
                     again = 1'b1;
                  end
               end
               M_NUMDOT: begin
                  if (is_dig(c)) mode = M_FRAC;
                  else begin
                     close_number(pos - 20'd1);
                     if (!stopped) begin
                        tok_off = pos - 20'd1;
                        tok_col = cl - 16'd1;
                        if (c == ".") mode = M_DOT2;
                        else begin
                           add_tok(TK_DOT, tok_col, tok_off, 1, '0, ERR_NONE);
                           again = 1'b1;
                        end
                     end
                  end
               end
               M_FRAC: begin
                  if (!is_dig(c)) begin
                     mode = M_IDLE;
                     add_tok(TK_FLOAT, tok_col, tok_off, pos - tok_off, '0, ERR_NONE);
                     again = 1'b1;
                  end
               end
               M_NAME: begin
                  if (is_let(c) || is_dig(c) || c == "_") begin
                     if (name_len < 8) name_str = $sformatf("%s%c", name_str, c);
                     if (name_len < 9) name_len++;
                  end else begin
                     close_name(pos);
                     again = 1'b1;
                  end
               end
               default: again = 1'b1;
            endcase
            if (again && !stopped) open_token(c, pos, cl);
            offset = pos + 20'd1;
            col    = nl_idle ? 16'd0 : (nl_str ? 16'd1 : cl + 16'd1);
         end
         if (beats_now > 0) expected_q[expected_q.size() - 1].last = 1'b1;
      endfunction

      function void check_beat(token_beat_t got);
         token_beat_t e;
         if (expected_q.size() == 0) begin
            $error("token beat with nothing expected: kind %0d", got.tok.kind);
            fails++;
            return;
         end
         e = expected_q.pop_front();
         if (got.tok.kind !== e.tok.kind) begin
            $error("token_kind expected %0d actual %0d", e.tok.kind, got.tok.kind);
            fails++;
         end
         if (got.tok.row !== e.tok.row) begin
            $error("token_row expected %0d actual %0d", e.tok.row, got.tok.row);
            fails++;
         end
         if (got.tok.column !== e.tok.column) begin
            $error("token_column expected %0d actual %0d", e.tok.column, got.tok.column);
            fails++;
         end
         if (got.tok.start !== e.tok.start) begin
            $error("span_start expected %0d actual %0d", e.tok.start, got.tok.start);
            fails++;
         end
         if (got.tok.length !== e.tok.length) begin
            $error("span_length expected %0d actual %0d", e.tok.length, got.tok.length);
            fails++;
         end
         if (got.tok.value !== e.tok.value) begin
            $error("literal_value expected %0d actual %0d", e.tok.value, got.tok.value);
            fails++;
         end
         if (got.tok.err !== e.tok.err) begin
            $error("error_code expected %0d actual %0d", e.tok.err, got.tok.err);
            fails++;
         end
         if (got.last !== e.last) begin
            $error("last_result expected %0d actual %0d", e.last, got.last);
            fails++;
         end
      endfunction
   endclass

   localparam int IDLE_LIMIT = 5000;

   logic clock;
   logic reset;
   logic csr_write_en;
   logic csr_write_data;

   ctl_req_if req();
   ctl_rsp_if rsp();

   c_token_lexer_core DUT (
      .clock          (clock),
      .reset          (reset),
      .req_if         (req),
      .rsp_if         (rsp),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   token_scoreboard lexer_sb = new();

   logic [7:0] text_q[$];
   int         send_idle_pct;
   int         rsp_stall_pct;
   int         hold_left;
   int         quiet_cycles;

   string name_head = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
   string name_body = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
   string punct_set = "()[]{},-+;*%";
   string op_words[14] = '{"/", "//", "!", "!=", "=", "==", "<", "<=", ">", ">=",
                           "&", "&&", "|", "||"};
   string kw_words[8]  = '{"return", "if", "else", "for", "while", "struct",
                           "typedef", "const"};
   logic [7:0] blank_set[4] = '{" ", CH_TAB, CH_CR, CH_LF};

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function void add_str(string s);
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endfunction

   function void add_digits(int n);
      for (int i = 0; i < n; i++) text_q.push_back(8'd48 + $urandom_range(9));
   endfunction

   // one random well-formed lexeme plus optional blanks
   function void add_lexeme();
      int   pick;
      int   n;
      logic [7:0] b;
      logic must_split;
      pick       = $urandom_range(11);
      must_split = 1'b0;
      case (pick)
         0: text_q.push_back(punct_set[$urandom_range(punct_set.len() - 1)]);
         1: add_str(op_words[$urandom_range(13)]);
         2: add_str($urandom_range(2) == 0 ? "." : ($urandom_range(1) ? ".." : "..."));
         3: add_str(kw_words[$urandom_range(7)]);
         4: begin
            must_split = 1'b1;
            if ($urandom_range(9) == 0) add_str("2147483647");
            else add_digits($urandom_range(1, 9));
            if ($urandom_range(4) == 0) begin
               text_q.push_back(name_head[$urandom_range(51)]);
               if ($urandom_range(1)) add_digits($urandom_range(1, 3));
            end
         end
         5: begin
            must_split = 1'b1;
            add_digits($urandom_range(1, 4));
            case ($urandom_range(3))
               0: add_str(".");
               1: add_str("..");
               2: add_str("...");
               default: begin
                  add_str(".");
                  add_digits($urandom_range(1, 3));
               end
            endcase
         end
         6: begin
            text_q.push_back("\"");
            n = $urandom_range(6);
            for (int i = 0; i < n; i++) begin
               b = $urandom_range(3) == 0 ? CH_LF : 8'($urandom_range(255));
               text_q.push_back(b == "\"" ? 8'h7E : b);
            end
            text_q.push_back("\"");
         end
         7: begin
            text_q.push_back("'");
            text_q.push_back(8'($urandom_range(255)));
            text_q.push_back($urandom_range(3) == 0 ? 8'($urandom_range(255)) : 8'h27);
         end
         default: begin
            n = $urandom_range(0, 3) == 0 ? $urandom_range(8, 12) : $urandom_range(1, 5);
            text_q.push_back(name_head[$urandom_range(52 - 1)]);
            for (int i = 1; i < n; i++) text_q.push_back(name_body[$urandom_range(62 - 1)]);
         end
      endcase
      if (must_split || $urandom_range(9) < 7) begin
         n = $urandom_range(1, 2);
         for (int i = 0; i < n; i++) text_q.push_back(blank_set[$urandom_range(3)]);
      end
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic eot);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req.valid = 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req.valid       = 1'b1;
      req.text_byte   = b;
      req.end_of_text = eot;
      do @(posedge clock); while (!req.ready);
      lexer_sb.note_byte(b, eot);
      @(negedge clock);
   endtask

   task automatic send_text();
      while (text_q.size() > 0) send_byte(text_q.pop_front(), 1'b0);
   endtask

   task automatic drain_tokens();
      req.valid = 1'b0;
      while (lexer_sb.expected_q.size() > 0) @(negedge clock);
      // a byte with no token may still sit in the pipe
      repeat (8) @(negedge clock);
   endtask

   task automatic write_row_base(input logic v);
      csr_write_en   = 1'b1;
      csr_write_data = v;
      @(negedge clock);
      lexer_sb.write_first_row(v);
      csr_write_en = 1'b0;
   endtask

   // response side: random stall, plus long hold-offs on request
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp.ready = 1'b0;
         hold_left--;
      end else begin
         rsp.ready = ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      token_beat_t got;
      if (!reset && rsp.valid && rsp.ready) begin
         got.tok.kind   = rsp.token_kind;
         got.tok.row    = rsp.token_row;
         got.tok.column = rsp.token_column;
         got.tok.start  = rsp.span_start;
         got.tok.length = rsp.span_length;
         got.tok.value  = rsp.literal_value;
         got.tok.err    = rsp.error_code;
         got.last       = rsp.last_result;
         lexer_sb.check_beat(got);
      end
   end

   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      int stop_pick;
      reset           = 1'b1;
      csr_write_en    = 1'b0;
      csr_write_data  = 1'b0;
      req.valid       = 1'b0;
      req.text_byte   = '0;
      req.end_of_text = 1'b0;
      rsp.ready       = 1'b0;
      send_idle_pct   = 0;
      rsp_stall_pct   = 0;
      hold_left       = 0;
      quiet_cycles    = 0;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // both settings before any byte; the second reloads the row counter
      write_row_base(1'b1);
      write_row_base(1'b0);

      // directed: operators, dot forms, number tails, string rows, char bytes
      add_str("if(x_9<=1.5)'");
      text_q.push_back(8'hFF);
      text_q.push_back(8'h00);
      add_str("\"a");
      text_q.push_back(CH_LF);
      add_str("\"7..4.x 2147483647ab");
      send_text();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  hold_left = 300; end
            1: begin send_idle_pct = 81; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 81; end
            default: begin send_idle_pct = 24; rsp_stall_pct = 24; end
         endcase
         while (text_q.size() < 125) add_lexeme();
         send_text();
         drain_tokens();
         write_row_base(phase[0] ? 1'b0 : 1'b1);
      end

      // one stopping condition closes the text
      add_lexeme();
      send_text();
      stop_pick = $urandom_range(3);
      case (stop_pick)
         0: send_byte(8'($urandom_range(255)), 1'b1);
         1: send_byte($urandom_range(1) ? 8'($urandom_range(128, 255)) : 8'h40, 1'b0);
         2: begin
            add_str(" \"ab");
            send_text();
            send_byte(8'h00, 1'b1);
         end
         default: begin
            add_str(" 99999999999 ");
            send_text();
         end
      endcase
      // stopped lexer drops everything from here on
      for (int i = 0; i < 20; i++)
         send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
      req.valid = 1'b0;

      while (lexer_sb.expected_q.size() > 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (lexer_sb.fails == 0 && lexer_sb.expected_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

@@ filelist.f @@
+incdir+src
src/ctl_pkg.sv
src/ctl_if.sv
src/ctl_front.sv
src/ctl_queue.sv
src/ctl_back.sv
src/c_token_lexer_core.sv
bench/tb_top.sv
